// File: rtl/core/pnd_pkg.sv
// Package for the pendulum PID motor drive: register codes, reset values,
// field widths and the structs passed between the pipeline blocks.
// No dependencies.
`default_nettype none

package pnd_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CNT_W = 16;
  localparam int unsigned GAIN_W = 16;
  localparam int unsigned LIMIT_W = 10;
  localparam int unsigned ERR_W = 17;
  localparam int unsigned DE_W = 18;
  localparam int unsigned INTEG_W = 32;
  localparam int unsigned FRAC_BITS = 8;
  localparam int unsigned DRV_W = 11;
  localparam int unsigned PWM_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_PEND_SETPOINT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CARRIAGE_CENTER = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CARRIAGE_LIMIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FALL_OFFSET = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KP_GAIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KD_GAIN = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_KI_GAIN = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT = 3'd7;

  localparam logic [CNT_W-1:0] RST_PEND_SETPOINT = 16'd32000;
  localparam logic [CNT_W-1:0] RST_CARRIAGE_CENTER = 16'd32000;
  localparam logic [CNT_W-1:0] RST_CARRIAGE_LIMIT = 16'd4500;
  localparam logic [CNT_W-1:0] RST_FALL_OFFSET = 16'd500;
  localparam logic [GAIN_W-1:0] RST_KP_GAIN = 16'd7680;
  localparam logic [GAIN_W-1:0] RST_KD_GAIN = 16'd11520;
  localparam logic [GAIN_W-1:0] RST_KI_GAIN = 16'd410;
  localparam logic [LIMIT_W-1:0] RST_DRIVE_LIMIT = 10'd500;

  localparam logic [PWM_W-1:0] RIGHT_OFFSET = 11'd17;
  localparam logic [PWM_W-1:0] LEFT_OFFSET = 11'd50;

  typedef struct packed {
    logic [CNT_W-1:0]   pend_setpoint;
    logic [CNT_W-1:0]   carriage_center;
    logic [CNT_W-1:0]   carriage_limit;
    logic [CNT_W-1:0]   fall_offset;
    logic [GAIN_W-1:0]  kp_gain;
    logic [GAIN_W-1:0]  kd_gain;
    logic [GAIN_W-1:0]  ki_gain;
    logic [LIMIT_W-1:0] drive_limit;
  } pnd_cfg_t;

  typedef struct packed {
    logic                      act;
    logic signed [ERR_W-1:0]   err;
    logic signed [DE_W-1:0]    de;
    logic signed [INTEG_W-1:0] integ;
  } pnd_err_t;

endpackage

`default_nettype wire

// File: rtl/core/pnd_cfg.sv
// Configuration register file of the pendulum PID motor drive.
// Depends on pnd_pkg for the register codes and reset values.
`default_nettype none

module pnd_cfg
  import pnd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output pnd_cfg_t              cfg
);

  pnd_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pend_setpoint <= RST_PEND_SETPOINT;
      cfg_r.carriage_center <= RST_CARRIAGE_CENTER;
      cfg_r.carriage_limit <= RST_CARRIAGE_LIMIT;
      cfg_r.fall_offset <= RST_FALL_OFFSET;
      cfg_r.kp_gain <= RST_KP_GAIN;
      cfg_r.kd_gain <= RST_KD_GAIN;
      cfg_r.ki_gain <= RST_KI_GAIN;
      cfg_r.drive_limit <= RST_DRIVE_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PEND_SETPOINT: cfg_r.pend_setpoint <= cfg_data;
        REG_CARRIAGE_CENTER: cfg_r.carriage_center <= cfg_data;
        REG_CARRIAGE_LIMIT: cfg_r.carriage_limit <= cfg_data;
        REG_FALL_OFFSET: cfg_r.fall_offset <= cfg_data;
        REG_KP_GAIN: cfg_r.kp_gain <= cfg_data;
        REG_KD_GAIN: cfg_r.kd_gain <= cfg_data;
        REG_KI_GAIN: cfg_r.ki_gain <= cfg_data;
        REG_DRIVE_LIMIT: cfg_r.drive_limit <= cfg_data[LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// File: rtl/core/pnd_front.sv
// Input register, stop test, error, error difference and saturating integral.
// Holds the previous error and the integral. Depends on pnd_pkg.
`default_nettype none

module pnd_front
  import pnd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  pnd_cfg_t         cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [CNT_W-1:0] in_pend,
  input  logic [CNT_W-1:0] in_car,
  output logic             s1_valid,
  input  logic             s1_ready,
  output pnd_err_t         s1
);

  logic                      s0_v_r;
  logic [CNT_W-1:0]          s0_pend_r;
  logic [CNT_W-1:0]          s0_car_r;
  logic                      s1_v_r;
  pnd_err_t                  s1_r;
  logic signed [ERR_W-1:0]   prev_err_r;
  logic signed [INTEG_W-1:0] integ_r;

  logic                      s1_load;
  logic                      step;
  logic [CNT_W-1:0]          pend_dist;
  logic [CNT_W-1:0]          car_dist;
  logic                      act;
  logic signed [ERR_W-1:0]   err;
  logic signed [DE_W-1:0]    de;
  logic signed [INTEG_W:0]   isum;
  logic signed [INTEG_W-1:0] integ_nxt;

  assign s1_load = !s1_v_r || s1_ready;
  assign in_ready = !s0_v_r || s1_load;
  assign step = s0_v_r && s1_load;

  always_comb begin
    pend_dist = (s0_pend_r >= cfg.pend_setpoint) ? s0_pend_r - cfg.pend_setpoint
                                                 : cfg.pend_setpoint - s0_pend_r;
    car_dist = (s0_car_r >= cfg.carriage_center) ? s0_car_r - cfg.carriage_center
                                                 : cfg.carriage_center - s0_car_r;
    act = !((pend_dist == cfg.fall_offset) || (car_dist >= cfg.carriage_limit));
    err = $signed({1'b0, cfg.pend_setpoint}) - $signed({1'b0, s0_pend_r});
    de = $signed({err[ERR_W-1], err}) - $signed({prev_err_r[ERR_W-1], prev_err_r});
    isum = $signed({integ_r[INTEG_W-1], integ_r})
         + $signed({{(INTEG_W+1-ERR_W){err[ERR_W-1]}}, err});
    if (isum[INTEG_W] != isum[INTEG_W-1]) begin
      integ_nxt = isum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}} : {1'b0, {(INTEG_W-1){1'b1}}};
    end else begin
      integ_nxt = isum[INTEG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
      s1_v_r <= 1'b0;
      prev_err_r <= '0;
      integ_r <= '0;
    end else begin
      if (in_ready) begin
        s0_v_r <= in_valid;
      end
      if (s1_load) begin
        s1_v_r <= s0_v_r;
      end
      if (step && act) begin
        prev_err_r <= err;
        integ_r <= integ_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s0_pend_r <= in_pend;
      s0_car_r <= in_car;
    end
    if (step) begin
      s1_r.act <= act;
      s1_r.err <= err;
      s1_r.de <= de;
      s1_r.integ <= integ_nxt;
    end
  end

  assign s1_valid = s1_v_r;
  assign s1 = s1_r;

endmodule

`default_nettype wire

// File: rtl/core/pnd_terms.sv
// PID products, per-term and sum saturation, output history and running total.
// The running total is kept by adding the new sum and dropping the oldest one.
// Depends on pnd_pkg.
`default_nettype none

module pnd_terms
  import pnd_pkg::*;
#(
  parameter int HISTORY_DEPTH = 5,
  parameter int TERM_WIDTH = 48,
  localparam int TOTW = TERM_WIDTH + $clog2(HISTORY_DEPTH) + 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  pnd_cfg_t               cfg,
  input  logic                   s1_valid,
  output logic                   s1_ready,
  input  pnd_err_t               s1,
  output logic                   s4_valid,
  input  logic                   s4_ready,
  output logic                   s4_act,
  output logic signed [TOTW-1:0] s4_total
);

  localparam int PW = GAIN_W + 1 + ERR_W;
  localparam int DW = GAIN_W + 1 + DE_W;
  localparam int IW = GAIN_W + 1 + INTEG_W;
  localparam int SW = ((TERM_WIDTH > IW) ? TERM_WIDTH : IW) + 2;
  localparam logic signed [SW-1:0] TMAX = SW'((64'sd1 <<< (TERM_WIDTH - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] TMIN = ~TMAX;

  function automatic logic signed [SW-1:0] sat_t(input logic signed [SW-1:0] v);
    if (v > TMAX) begin
      return TMAX;
    end else if (v < TMIN) begin
      return TMIN;
    end
    return v;
  endfunction

  logic                         s2_v_r;
  logic                         s2_act_r;
  logic signed [PW-1:0]         s2_p_r;
  logic signed [DW-1:0]         s2_d_r;
  logic signed [IW-1:0]         s2_i_r;
  logic                         s3_v_r;
  logic                         s3_act_r;
  logic signed [TERM_WIDTH-1:0] s3_s_r;
  logic                         s4_v_r;
  logic                         s4_act_r;
  logic signed [TERM_WIDTH-1:0] hist_r [HISTORY_DEPTH];
  logic signed [TOTW-1:0]       total_r;

  logic                         s2_load;
  logic                         s3_load;
  logic                         s4_load;
  logic signed [PW-1:0]         p_nxt;
  logic signed [DW-1:0]         d_nxt;
  logic signed [IW-1:0]         i_nxt;
  logic signed [SW-1:0]         sum3;
  logic signed [SW-1:0]         s_sat;
  logic signed [TOTW-1:0]       total_nxt;
  logic                         h_step;

  assign s4_load = !s4_v_r || s4_ready;
  assign s3_load = !s3_v_r || s4_load;
  assign s2_load = !s2_v_r || s3_load;
  assign s1_ready = s2_load;
  assign h_step = s3_v_r && s4_load && s3_act_r;

  always_comb begin
    p_nxt = $signed({1'b0, cfg.kp_gain}) * $signed(s1.err);
    d_nxt = $signed({1'b0, cfg.kd_gain}) * $signed(s1.de);
    i_nxt = $signed({1'b0, cfg.ki_gain}) * $signed(s1.integ);
    sum3 = sat_t(SW'(s2_p_r)) + sat_t(SW'(s2_d_r)) + sat_t(SW'(s2_i_r));
    s_sat = sat_t(sum3);
    total_nxt = total_r + TOTW'(s3_s_r) - TOTW'(hist_r[0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      total_r <= '0;
      for (int k = 0; k < HISTORY_DEPTH; k++) begin
        hist_r[k] <= '0;
      end
    end else begin
      if (s2_load) begin
        s2_v_r <= s1_valid;
      end
      if (s3_load) begin
        s3_v_r <= s2_v_r;
      end
      if (s4_load) begin
        s4_v_r <= s3_v_r;
      end
      if (h_step) begin
        for (int k = 0; k < HISTORY_DEPTH - 1; k++) begin
          hist_r[k] <= hist_r[k+1];
        end
        hist_r[HISTORY_DEPTH-1] <= s3_s_r;
        total_r <= total_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s2_load) begin
      s2_act_r <= s1.act;
      s2_p_r <= p_nxt;
      s2_d_r <= d_nxt;
      s2_i_r <= i_nxt;
    end
    if (s2_v_r && s3_load) begin
      s3_act_r <= s2_act_r;
      s3_s_r <= s_sat[TERM_WIDTH-1:0];
    end
    if (s3_v_r && s4_load) begin
      s4_act_r <= s3_act_r;
    end
  end

  assign s4_valid = s4_v_r;
  assign s4_act = s4_act_r;
  assign s4_total = total_r;

endmodule

`default_nettype wire

// File: rtl/core/pnd_scale.sv
// Average of the history total, round half to even, drive clamp, PWM compares
// and the result register. The divide by the history depth is a reciprocal
// multiply with one correction step. Depends on pnd_pkg.
`default_nettype none

module pnd_scale
  import pnd_pkg::*;
#(
  parameter int HISTORY_DEPTH = 5,
  parameter int TERM_WIDTH = 48,
  localparam int TOTW = TERM_WIDTH + $clog2(HISTORY_DEPTH) + 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [LIMIT_W-1:0]      drive_limit,
  input  logic                    s4_valid,
  output logic                    s4_ready,
  input  logic                    s4_act,
  input  logic signed [TOTW-1:0]  s4_total,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_motor_enable,
  output logic [PWM_W-1:0]        out_pwm_right,
  output logic [PWM_W-1:0]        out_pwm_left,
  output logic signed [DRV_W-1:0] out_drive_value,
  output logic                    out_running
);

  // Quotients beyond the bias always clamp, so the scaled total is limited
  // first and then biased to a small unsigned value.
  localparam int QBIAS = 1025;
  localparam int XLIM = QBIAS * HISTORY_DEPTH;
  localparam int XW = TOTW - FRAC_BITS;
  localparam int UW = $clog2(2 * XLIM + 1);
  localparam int RW = $clog2(HISTORY_DEPTH);
  localparam logic signed [XW-1:0] XHI = XW'(XLIM);
  localparam logic signed [XW-1:0] XLO = -XHI;
  localparam logic [UW-1:0] MUL = UW'((1 << UW) / HISTORY_DEPTH);
  localparam logic [UW-1:0] DEP_U = UW'(HISTORY_DEPTH);
  localparam logic [RW+FRAC_BITS-1:0] HALF = (RW + FRAC_BITS)'(HISTORY_DEPTH * 128);
  localparam logic signed [UW:0] QB = (UW + 1)'(QBIAS);

  logic                    s5_v_r;
  logic                    s5_act_r;
  logic [UW-1:0]           s5_qe_r;
  logic [UW-1:0]           s5_u_r;
  logic [FRAC_BITS-1:0]    s5_low_r;
  logic                    s6_v_r;
  logic                    s6_act_r;
  logic signed [DRV_W-1:0] s6_drive_r;
  logic                    out_valid_r;
  logic                    motor_enable_r;
  logic [PWM_W-1:0]        pwm_right_r;
  logic [PWM_W-1:0]        pwm_left_r;
  logic signed [DRV_W-1:0] drive_r;
  logic                    running_r;

  logic                    out_load;
  logic                    s6_load;
  logic                    s5_load;
  logic signed [XW-1:0]    x;
  logic signed [XW-1:0]    xc;
  logic signed [XW-1:0]    xb;
  logic [UW-1:0]           u;
  logic [2*UW-1:0]         prod;
  logic [UW-1:0]           qd;
  logic [UW-1:0]           rem;
  logic                    corr;
  logic [UW-1:0]           qu;
  logic [UW-1:0]           rfin;
  logic [RW+FRAC_BITS-1:0] rr;
  logic                    up;
  logic [UW-1:0]           qr;
  logic signed [UW:0]      qs;
  logic signed [UW:0]      lim;
  logic signed [UW:0]      dsat;

  assign out_load = !out_valid_r || out_ready;
  assign s6_load = !s6_v_r || out_load;
  assign s5_load = !s5_v_r || s6_load;
  assign s4_ready = s5_load;

  always_comb begin
    x = $signed(s4_total[TOTW-1:FRAC_BITS]);
    if (x > XHI) begin
      xc = XHI;
    end else if (x < XLO) begin
      xc = XLO;
    end else begin
      xc = x;
    end
    xb = xc + XHI;
    u = xb[UW-1:0];
    prod = u * MUL;
  end

  always_comb begin
    qd = s5_qe_r * DEP_U;
    rem = s5_u_r - qd;
    corr = rem >= DEP_U;
    qu = s5_qe_r + UW'(corr);
    rfin = corr ? rem - DEP_U : rem;
    rr = {rfin[RW-1:0], s5_low_r};
    // The bias is odd, so an even biased quotient is an odd true quotient.
    up = (rr > HALF) || ((rr == HALF) && !qu[0]);
    qr = qu + UW'(up);
    qs = $signed({1'b0, qr}) - QB;
    lim = $signed((UW + 1)'(drive_limit));
    if (qs > lim) begin
      dsat = lim;
    end else if (qs < -lim) begin
      dsat = -lim;
    end else begin
      dsat = qs;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
      s6_v_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s5_load) begin
        s5_v_r <= s4_valid;
      end
      if (s6_load) begin
        s6_v_r <= s5_v_r;
      end
      if (out_load) begin
        out_valid_r <= s6_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s4_valid && s5_load) begin
      s5_act_r <= s4_act;
      s5_qe_r <= prod[2*UW-1:UW];
      s5_u_r <= u;
      s5_low_r <= s4_total[FRAC_BITS-1:0];
    end
    if (s5_v_r && s6_load) begin
      s6_act_r <= s5_act_r;
      s6_drive_r <= dsat[DRV_W-1:0];
    end
    if (s6_v_r && out_load) begin
      running_r <= s6_act_r;
      drive_r <= s6_act_r ? s6_drive_r : '0;
      motor_enable_r <= s6_act_r && (s6_drive_r != '0);
      pwm_right_r <= (s6_act_r && (s6_drive_r < 0))
                   ? PWM_W'(-s6_drive_r) + RIGHT_OFFSET : '0;
      pwm_left_r <= (s6_act_r && (s6_drive_r > 0))
                  ? PWM_W'(s6_drive_r) + LEFT_OFFSET : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_motor_enable = motor_enable_r;
  assign out_pwm_right = pwm_right_r;
  assign out_pwm_left = pwm_left_r;
  assign out_drive_value = drive_r;
  assign out_running = running_r;

endmodule

`default_nettype wire

// File: rtl/core/pendulum_pid_motor_drive.sv
// Pendulum PID motor drive, top level.
// Throughput: one beat per cycle while out_ready is held high; the only loops are the
// integral add and the running history total, each a single register stage.
// Reset restores the register defaults, clears the integral, previous error and
// history, and empties the pipeline.
`default_nettype none

module pendulum_pid_motor_drive
  import pnd_pkg::*;
#(
  parameter int HISTORY_DEPTH = 5,
  parameter int TERM_WIDTH = 48
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [CNT_W-1:0]        in_pendulum_count,
  input  logic [CNT_W-1:0]        in_carriage_count,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_motor_enable,
  output logic [PWM_W-1:0]        out_pwm_right,
  output logic [PWM_W-1:0]        out_pwm_left,
  output logic signed [DRV_W-1:0] out_drive_value,
  output logic                    out_running
);

  localparam int TOTW = TERM_WIDTH + $clog2(HISTORY_DEPTH) + 1;

  pnd_cfg_t               cfg;
  logic                   s1_valid;
  logic                   s1_ready;
  pnd_err_t               s1;
  logic                   s4_valid;
  logic                   s4_ready;
  logic                   s4_act;
  logic signed [TOTW-1:0] s4_total;

  pnd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pnd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_pend  (in_pendulum_count),
    .in_car   (in_carriage_count),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s1       (s1)
  );

  pnd_terms #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .TERM_WIDTH    (TERM_WIDTH)
  ) u_terms (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s1       (s1),
    .s4_valid (s4_valid),
    .s4_ready (s4_ready),
    .s4_act   (s4_act),
    .s4_total (s4_total)
  );

  pnd_scale #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .TERM_WIDTH    (TERM_WIDTH)
  ) u_scale (
    .clk              (clk),
    .rst_n            (rst_n),
    .drive_limit      (cfg.drive_limit),
    .s4_valid         (s4_valid),
    .s4_ready         (s4_ready),
    .s4_act           (s4_act),
    .s4_total         (s4_total),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_motor_enable (out_motor_enable),
    .out_pwm_right    (out_pwm_right),
    .out_pwm_left     (out_pwm_left),
    .out_drive_value  (out_drive_value),
    .out_running      (out_running)
  );

endmodule

`default_nettype wire

// File: rtl/core/pnd_chk.sv
// Port checker for the pendulum PID motor drive and its bind to the top level.
// Depends on pnd_pkg for the PWM offsets.
`default_nettype none

module pnd_chk
  import pnd_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic                    out_motor_enable,
  input logic [PWM_W-1:0]        out_pwm_right,
  input logic [PWM_W-1:0]        out_pwm_left,
  input logic signed [DRV_W-1:0] out_drive_value,
  input logic                    out_running
);

  a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_running |-> !out_motor_enable && (out_drive_value == '0)
      && (out_pwm_right == '0) && (out_pwm_left == '0))
    else $error("Stopped beat carries a nonzero field.");

  a_enable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_motor_enable == (out_drive_value != '0))
    else $error("Motor enable does not match the drive value.");

  a_left: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_drive_value > 0) |->
      (out_pwm_left == PWM_W'(out_drive_value) + LEFT_OFFSET) && (out_pwm_right == '0))
    else $error("Left compare is wrong for a positive drive.");

  a_right: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_drive_value < 0) |->
      (out_pwm_right == PWM_W'(-out_drive_value) + RIGHT_OFFSET) && (out_pwm_left == '0))
    else $error("Right compare is wrong for a negative drive.");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_drive_value)
      && $stable(out_running))
    else $error("Stalled result beat changed.");

endmodule

bind pendulum_pid_motor_drive pnd_chk u_pnd_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_motor_enable (out_motor_enable),
  .out_pwm_right    (out_pwm_right),
  .out_pwm_left     (out_pwm_left),
  .out_drive_value  (out_drive_value),
  .out_running      (out_running)
);

`default_nettype wire

// File: sim/pendulum_pid_motor_drive_tb.sv
`timescale 1ns / 100ps
// Testbench for pendulum_pid_motor_drive: directed and random encoder beats, checked
// against a PID, averaging and drive predictor kept in this file, under idle/stall mixes.
// Depends on pnd_pkg and the block's RTL only.

module pendulum_pid_motor_drive_tb;
  import pnd_pkg::*;

  localparam int HIST_DEPTH = 5;
  localparam int TERM_W = 48;
  localparam int DRAIN_CYCLES = 12;
  localparam int MAX_REPORTS = 10;
  localparam int COUNT_MAX = (1 << CNT_W) - 1;
  localparam longint TERM_MAX = (longint'(1) << (TERM_W - 1)) - 1;
  localparam longint INTEG_MAX = (longint'(1) << (INTEG_W - 1)) - 1;
  localparam longint AVG_DIV = HIST_DEPTH * (1 << FRAC_BITS);

  localparam pnd_cfg_t RESET_CFG = '{RST_PEND_SETPOINT, RST_CARRIAGE_CENTER,
      RST_CARRIAGE_LIMIT, RST_FALL_OFFSET, RST_KP_GAIN, RST_KD_GAIN, RST_KI_GAIN,
      RST_DRIVE_LIMIT};

  typedef enum {TRAFFIC_FREE, TRAFFIC_SLOW_SEND, TRAFFIC_SLOW_RECV, TRAFFIC_BOTH} traffic_t;

  typedef struct packed {
    logic                    motor_enable;
    logic [PWM_W-1:0]        pwm_right;
    logic [PWM_W-1:0]        pwm_left;
    logic signed [DRV_W-1:0] drive_value;
    logic                    running;
  } drive_result_t;

  logic                    clk;
  logic                    rst_n = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = REG_PEND_SETPOINT;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [CNT_W-1:0]        in_pendulum_count = '0;
  logic [CNT_W-1:0]        in_carriage_count = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic                    out_motor_enable;
  logic [PWM_W-1:0]        out_pwm_right;
  logic [PWM_W-1:0]        out_pwm_left;
  logic signed [DRV_W-1:0] out_drive_value;
  logic                    out_running;

  pnd_cfg_t drive_cfg = RESET_CFG;
  longint prev_error = 0;
  longint integral_sum = 0;
  longint pid_history [HIST_DEPTH] = '{default: 0};
  drive_result_t expected_drive_q [$];

  int fail_count = 0;
  int beats_in = 0;
  int beats_out = 0;
  int settings_used = 1;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;

  pendulum_pid_motor_drive #(
    .HISTORY_DEPTH(HIST_DEPTH),
    .TERM_WIDTH(TERM_W)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_pendulum_count(in_pendulum_count),
    .in_carriage_count(in_carriage_count),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_motor_enable(out_motor_enable),
    .out_pwm_right(out_pwm_right),
    .out_pwm_left(out_pwm_left),
    .out_drive_value(out_drive_value),
    .out_running(out_running)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [CNT_W-1:0] count_distance(input logic [CNT_W-1:0] a, b);
    return (a >= b) ? a - b : b - a;
  endfunction

  function automatic void predict_tick(input logic [CNT_W-1:0] pend, car);
    drive_result_t res;
    longint err, p_term, d_term, i_term, pid_sum, total, quot, rem, drive, mag;
    res = '0;
    if (count_distance(pend, drive_cfg.pend_setpoint) == drive_cfg.fall_offset ||
        count_distance(car, drive_cfg.carriage_center) >= drive_cfg.carriage_limit) begin
      expected_drive_q.push_back(res);
      return;
    end
    err = longint'(drive_cfg.pend_setpoint) - longint'(pend);
    integral_sum = clip(integral_sum + err, -INTEG_MAX - 1, INTEG_MAX);
    p_term = clip(longint'(drive_cfg.kp_gain) * err, -TERM_MAX - 1, TERM_MAX);
    d_term = clip(longint'(drive_cfg.kd_gain) * (err - prev_error), -TERM_MAX - 1, TERM_MAX);
    i_term = clip(longint'(drive_cfg.ki_gain) * integral_sum, -TERM_MAX - 1, TERM_MAX);
    pid_sum = clip(p_term + d_term + i_term, -TERM_MAX - 1, TERM_MAX);
    total = pid_sum;
    for (int k = 0; k + 1 < HIST_DEPTH; k++) begin
      pid_history[k] = pid_history[k + 1];
      total += pid_history[k];
    end
    pid_history[HIST_DEPTH - 1] = pid_sum;
    quot = total / AVG_DIV;
    rem = total % AVG_DIV;
    if (rem < 0) begin
      quot -= 1;
      rem += AVG_DIV;
    end
    if (2 * rem > AVG_DIV || (2 * rem == AVG_DIV && quot[0])) quot += 1;
    drive = clip(quot, -longint'(drive_cfg.drive_limit), longint'(drive_cfg.drive_limit));
    prev_error = err;
    res.running = 1'b1;
    res.drive_value = drive[DRV_W-1:0];
    if (drive < 0) begin
      mag = -drive;
      res.motor_enable = 1'b1;
      res.pwm_right = mag[PWM_W-1:0] + RIGHT_OFFSET;
    end else if (drive > 0) begin
      res.motor_enable = 1'b1;
      res.pwm_left = drive[PWM_W-1:0] + LEFT_OFFSET;
    end
    expected_drive_q.push_back(res);
  endfunction

  function automatic void report_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("%s", msg);
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      predict_tick(in_pendulum_count, in_carriage_count);
      beats_in++;
    end
  end

  always @(posedge clk) begin
    drive_result_t want;
    if (rst_n && out_valid && out_ready) begin
      beats_out++;
      if (expected_drive_q.size() == 0) begin
        report_failure($sformatf("result beat %0d arrived with nothing expected", beats_out));
      end else begin
        want = expected_drive_q.pop_front();
        if (out_motor_enable !== want.motor_enable || out_pwm_right !== want.pwm_right ||
            out_pwm_left !== want.pwm_left || out_drive_value !== want.drive_value ||
            out_running !== want.running) begin
          report_failure({$sformatf(
              "beat %0d: expected en=%0d right=%0d left=%0d drive=%0d run=%0d, ",
              beats_out, want.motor_enable, want.pwm_right, want.pwm_left,
              want.drive_value, want.running),
              $sformatf("got en=%0d right=%0d left=%0d drive=%0d run=%0d",
              out_motor_enable, out_pwm_right, out_pwm_left, out_drive_value,
              out_running)});
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic set_traffic(input traffic_t mode);
    case (mode)
      TRAFFIC_FREE: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      TRAFFIC_SLOW_SEND: begin
        send_idle_pct = 74;
        recv_stall_pct = 0;
      end
      TRAFFIC_SLOW_RECV: begin
        send_idle_pct = 0;
        recv_stall_pct = 74;
      end
      default: begin
        send_idle_pct = 12;
        recv_stall_pct = 12;
      end
    endcase
  endtask

  task automatic send_beat(input logic [CNT_W-1:0] pend, car);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_pendulum_count <= pend;
    in_carriage_count <= car;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_drive_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic load_settings(input pnd_cfg_t c);
    logic [CFG_DATA_W-1:0] upper;
    upper = CFG_DATA_W'($urandom);
    cfg_put(REG_PEND_SETPOINT, c.pend_setpoint);
    cfg_put(REG_CARRIAGE_CENTER, c.carriage_center);
    cfg_put(REG_CARRIAGE_LIMIT, c.carriage_limit);
    cfg_put(REG_FALL_OFFSET, c.fall_offset);
    cfg_put(REG_KP_GAIN, c.kp_gain);
    cfg_put(REG_KD_GAIN, c.kd_gain);
    cfg_put(REG_KI_GAIN, c.ki_gain);
    cfg_put(REG_DRIVE_LIMIT, {upper[CFG_DATA_W-1:LIMIT_W], c.drive_limit});
    cfg_we <= 1'b0;
    drive_cfg = c;
    settings_used++;
  endtask

  function automatic logic [GAIN_W-1:0] random_gain();
    logic [GAIN_W-1:0] g;
    g = GAIN_W'($urandom);
    return g >> $urandom_range(0, GAIN_W - 1);
  endfunction

  function automatic pnd_cfg_t random_settings();
    pnd_cfg_t c;
    c.pend_setpoint = CNT_W'($urandom);
    c.carriage_center = CNT_W'($urandom);
    c.carriage_limit = CNT_W'(($urandom_range(0, 3) == 0) ? $urandom
                                                          : $urandom_range(1, 8000));
    c.fall_offset = CNT_W'($urandom_range(0, 1) ? $urandom_range(0, 2000) : $urandom);
    c.kp_gain = random_gain();
    c.kd_gain = random_gain();
    c.ki_gain = random_gain();
    c.drive_limit = LIMIT_W'($urandom);
    return c;
  endfunction

  // Most beats keep the carriage inside its limit, most of those near upright, so the
  // PID state keeps evolving; the rest hit the stop conditions or are plain noise.
  function automatic void pick_counts(output logic [CNT_W-1:0] pend, car);
    int kind, spread, reach, sp, ctr, lim, fall;
    kind = $urandom_range(0, 99);
    sp = int'(drive_cfg.pend_setpoint);
    ctr = int'(drive_cfg.carriage_center);
    lim = int'(drive_cfg.carriage_limit);
    fall = int'(drive_cfg.fall_offset);
    spread = ($urandom_range(0, 3) == 0) ? COUNT_MAX : 700;
    reach = (lim > 0) ? lim - 1 : 0;
    pend = CNT_W'(clip(sp + int'($urandom_range(0, 2 * spread)) - spread, 0, COUNT_MAX));
    car = CNT_W'(clip(ctr + int'($urandom_range(0, 2 * reach)) - reach, 0, COUNT_MAX));
    if (kind >= 60 && kind < 72) begin
      pend = CNT_W'(clip($urandom_range(0, 1) ? sp + fall : sp - fall, 0, COUNT_MAX));
    end else if (kind >= 72 && kind < 84) begin
      reach = lim + int'($urandom_range(0, 40));
      car = CNT_W'(clip($urandom_range(0, 1) ? ctr + reach : ctr - reach, 0, COUNT_MAX));
    end else if (kind >= 84) begin
      pend = CNT_W'($urandom);
      car = CNT_W'($urandom);
    end
  endfunction

  task automatic send_random_beats(input int count);
    logic [CNT_W-1:0] pend, car;
    for (int k = 0; k < count; k++) begin
      pick_counts(pend, car);
      send_beat(pend, car);
    end
  endtask

  task automatic test_reset_directed();
    set_traffic(TRAFFIC_FREE);
    send_beat(RST_PEND_SETPOINT, RST_CARRIAGE_CENTER);
    send_beat('0, RST_CARRIAGE_CENTER);
    send_beat('1, RST_CARRIAGE_CENTER);
    send_beat(RST_PEND_SETPOINT + RST_FALL_OFFSET, RST_CARRIAGE_CENTER);
    send_beat(RST_PEND_SETPOINT - RST_FALL_OFFSET, RST_CARRIAGE_CENTER);
    send_beat(CNT_W'(RST_PEND_SETPOINT + RST_FALL_OFFSET - 1), RST_CARRIAGE_CENTER);
    send_beat(CNT_W'(RST_PEND_SETPOINT - RST_FALL_OFFSET + 1), RST_CARRIAGE_CENTER);
    send_beat(RST_PEND_SETPOINT, RST_CARRIAGE_CENTER + RST_CARRIAGE_LIMIT);
    send_beat(RST_PEND_SETPOINT, CNT_W'(RST_CARRIAGE_CENTER + RST_CARRIAGE_LIMIT - 1));
    send_beat(RST_PEND_SETPOINT, RST_CARRIAGE_CENTER - RST_CARRIAGE_LIMIT);
    send_beat(RST_PEND_SETPOINT, CNT_W'(RST_CARRIAGE_CENTER - RST_CARRIAGE_LIMIT + 1));
    send_beat(RST_PEND_SETPOINT, '0);
    send_beat(RST_PEND_SETPOINT, '1);
    send_beat(CNT_W'(RST_PEND_SETPOINT - 1000), RST_CARRIAGE_CENTER);
    send_beat(CNT_W'(RST_PEND_SETPOINT + 1000), CNT_W'(RST_CARRIAGE_CENTER + 100));
    send_beat(CNT_W'(RST_PEND_SETPOINT + 100), CNT_W'(RST_CARRIAGE_CENTER - 100));
    send_beat(CNT_W'(RST_PEND_SETPOINT - 100), RST_CARRIAGE_CENTER);
    send_beat(CNT_W'(RST_PEND_SETPOINT + 3), RST_CARRIAGE_CENTER);
    send_beat(RST_PEND_SETPOINT, RST_CARRIAGE_CENTER);
    send_beat(RST_PEND_SETPOINT, RST_CARRIAGE_CENTER);
    settle();
  endtask

  task automatic test_special_settings();
    pnd_cfg_t c;
    set_traffic(TRAFFIC_BOTH);
    c = RESET_CFG;
    c.carriage_limit = '0;
    load_settings(c);
    send_random_beats(8);
    send_beat(c.pend_setpoint, c.carriage_center);
    settle();
    c = RESET_CFG;
    c.drive_limit = '0;
    load_settings(c);
    send_random_beats(10);
    settle();
    c = RESET_CFG;
    c.kp_gain = '0;
    c.kd_gain = '0;
    c.ki_gain = '0;
    c.drive_limit = '1;
    load_settings(c);
    send_random_beats(10);
    settle();
    c = RESET_CFG;
    c.fall_offset = '0;
    load_settings(c);
    send_beat(c.pend_setpoint, c.carriage_center);
    send_beat(CNT_W'(c.pend_setpoint + 1), c.carriage_center);
    send_beat(CNT_W'(c.pend_setpoint - 1), c.carriage_center);
    send_random_beats(6);
    settle();
  endtask

  task automatic test_register_extremes();
    pnd_cfg_t c;
    set_traffic(TRAFFIC_BOTH);
    c = '0;
    load_settings(c);
    send_random_beats(15);
    settle();
    c = '1;
    load_settings(c);
    send_random_beats(15);
    settle();
    c = '1;
    c.pend_setpoint = '0;
    c.fall_offset = '0;
    load_settings(c);
    send_random_beats(15);
    settle();
  endtask

  task automatic test_output_backpressure();
    load_settings(random_settings());
    set_traffic(TRAFFIC_FREE);
    hold_left = 300;
    send_random_beats(60);
    settle();
  endtask

  task automatic test_random_traffic();
    for (int blk = 0; blk < 8; blk++) begin
      set_traffic(traffic_t'(blk % 4));
      load_settings(random_settings());
      send_random_beats(180);
      settle();
    end
  endtask

  // Runs of near full scale error wind the integral far up one way and then
  // back down the other, with the largest gains.
  task automatic test_integral_windup();
    pnd_cfg_t c;
    set_traffic(TRAFFIC_FREE);
    c = '1;
    c.carriage_center = CNT_W'(COUNT_MAX / 2);
    c.fall_offset = '0;
    load_settings(c);
    for (int k = 0; k < 200; k++) begin
      send_beat(CNT_W'($urandom_range(0, 15)), CNT_W'($urandom));
    end
    settle();
    c.pend_setpoint = '0;
    c.fall_offset = '1;
    load_settings(c);
    for (int k = 0; k < 200; k++) begin
      send_beat(CNT_W'(COUNT_MAX - int'($urandom_range(0, 15))), CNT_W'($urandom));
    end
    settle();
  endtask

  initial begin
    rst_n <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_directed();
    test_special_settings();
    test_register_extremes();
    test_output_backpressure();
    test_random_traffic();
    test_integral_windup();
    settle();
    $display("Checked %0d result beats for %0d input beats over %0d register settings,",
        beats_out, beats_in, settings_used);
    $display("with idle and stall mixes, a long output stall and integral windup both ways.");
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d failing beats", fail_count);
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("timeout with %0d results outstanding", expected_drive_q.size());
    $display("simulation failed");
    $finish;
  end

endmodule

// File: files.f
rtl/core/pnd_pkg.sv
rtl/core/pnd_cfg.sv
rtl/core/pnd_front.sv
rtl/core/pnd_terms.sv
rtl/core/pnd_scale.sv
rtl/core/pendulum_pid_motor_drive.sv
rtl/core/pnd_chk.sv
sim/pendulum_pid_motor_drive_tb.sv
